>>> src/sfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, constants, effect tables and the RGB565 shade function of the
// sprite effect blitter.
// ----------------------------------------------------------------------------
package sfb_pkg;

    // Screen and sprite geometry
    localparam int SCREEN_COLUMNS  = 320;
    localparam int SCREEN_ROWS     = 240;
    localparam int MAX_SPRITE_SIDE = 1024;
    localparam int COUNT_W         = $clog2(MAX_SPRITE_SIDE);
    localparam logic [7:0] FLASH_FRAMES = 8'd16;

    // Position arithmetic: 11-bit origin plus 10-bit count plus small offset
    localparam int POS_W = 13;

    // Channel limits for the clamped shade
    localparam logic signed [7:0] RB_MAX = 8'sd31;
    localparam logic signed [7:0] G_MAX  = 8'sd63;

    // Flash brightening step
    localparam logic signed [4:0] FLASH_DELTA = 5'sd8;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ROW_PIXELS   = 3'd0;
    localparam logic [2:0] REG_DEST_X       = 3'd1;
    localparam logic [2:0] REG_DEST_Y       = 3'd2;
    localparam logic [2:0] REG_KEY_COLOUR   = 3'd3;
    localparam logic [2:0] REG_EFFECT_MODE  = 3'd4;
    localparam logic [2:0] REG_EFFECT_FRAME = 3'd5;
    localparam logic [2:0] REG_SIL_COLOUR   = 3'd6;
    localparam logic [2:0] REG_BUFFER_BASE  = 3'd7;

    // Effect modes; the two spare codes draw as plain
    typedef enum logic [2:0] {
        EFF_PLAIN      = 3'd0,
        EFF_SHAKE      = 3'd1,
        EFF_BOB        = 3'd2,
        EFF_FLASH      = 3'd3,
        EFF_PULSE      = 3'd4,
        EFF_SILHOUETTE = 3'd5
    } effect_t;

    // Configuration registers as one group
    typedef struct packed {
        logic [9:0]  row_pixels;
        logic [10:0] dest_x;
        logic [10:0] dest_y;
        logic [15:0] key_colour;
        logic [2:0]  effect_mode;
        logic [7:0]  effect_frame;
        logic [15:0] fill_colour;
        logic [31:0] buffer_base;
    } cfg_t;

    // One computed pixel write
    typedef struct packed {
        logic        draw;
        logic [31:0] address;
        logic [15:0] colour;
    } pix_result_t;

    // Shake x offset, frames 0..11
    function automatic logic [3:0] shake_dx(input logic [3:0] idx);
        logic [3:0] v;
        case (idx)
            4'd1:    v = 4'b1100;
            4'd2:    v = 4'b0100;
            4'd3:    v = 4'b1100;
            4'd4:    v = 4'b0100;
            4'd5:    v = 4'b1110;
            4'd6:    v = 4'b0010;
            4'd7:    v = 4'b1110;
            4'd8:    v = 4'b0010;
            4'd9:    v = 4'b1111;
            4'd10:   v = 4'b0001;
            default: v = 4'b0000;
        endcase
        return v;
    endfunction

    // Shade pulse delta, frame modulo 8
    function automatic logic [4:0] pulse_delta(input logic [2:0] idx);
        logic [4:0] v;
        case (idx)
            3'd0:    v = 5'b11010;
            3'd1:    v = 5'b11101;
            3'd3:    v = 5'b00011;
            3'd4:    v = 5'b00110;
            3'd5:    v = 5'b00011;
            3'd7:    v = 5'b11101;
            default: v = 5'b00000;
        endcase
        return v;
    endfunction

    // Bob y offset, frame modulo 8
    function automatic logic [1:0] bob_dy(input logic [2:0] idx);
        logic [1:0] v;
        case (idx)
            3'd1, 3'd2: v = 2'b11;
            3'd5, 3'd6: v = 2'b01;
            default:    v = 2'b00;
        endcase
        return v;
    endfunction

    // Silhouette jitter x offset, frames 0..15
    function automatic logic [1:0] jitter_dx(input logic [3:0] idx);
        logic [1:0] v;
        case (idx)
            4'd2, 4'd6, 4'd12: v = 2'b11;
            4'd4, 4'd8, 4'd14: v = 2'b01;
            default:           v = 2'b00;
        endcase
        return v;
    endfunction

    // Add delta per channel (twice on green) and clamp to the channel range
    function automatic logic [15:0] tint_rgb565(input logic [15:0] c,
                                                input logic [4:0]  d);
        logic signed [7:0] r;
        logic signed [7:0] g;
        logic signed [7:0] b;
        logic [4:0] r_out;
        logic [5:0] g_out;
        logic [4:0] b_out;
        r = $signed({3'b000, c[15:11]}) + $signed({{3{d[4]}}, d});
        g = $signed({2'b00, c[10:5]}) + $signed({{2{d[4]}}, d, 1'b0});
        b = $signed({3'b000, c[4:0]}) + $signed({{3{d[4]}}, d});
        r_out = r[7] ? 5'd0 : ((r > RB_MAX) ? 5'd31 : r[4:0]);
        g_out = g[7] ? 6'd0 : ((g > G_MAX) ? 6'd63 : g[5:0]);
        b_out = b[7] ? 5'd0 : ((b > RB_MAX) ? 5'd31 : b[4:0]);
        return {r_out, g_out, b_out};
    endfunction

endpackage

>>> src/sfb_pixel_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_pixel_calc
// Per-pixel effect, colour key, clip and framebuffer address logic. Purely
// combinational; sits between the input stage and the result register.
// ----------------------------------------------------------------------------
module sfb_pixel_calc
    import sfb_pkg::*;
(
    input  cfg_t                 cfg,
    input  logic [15:0]          pixel,
    input  logic [COUNT_W-1:0]   column,
    input  logic [COUNT_W-1:0]   row,
    output pix_result_t          result
);

    logic [7:0]        frame;
    logic              frame_lt12;
    logic              frame_lt16;
    logic [3:0]        dx;
    logic [1:0]        dy;
    logic [15:0]       colour;
    logic              keep;
    logic [POS_W-1:0]  x_pos;
    logic [POS_W-1:0]  y_pos;
    logic              x_in;
    logic              y_in;

    assign frame      = cfg.effect_frame;
    assign frame_lt12 = !frame[7] && (frame < 8'd12);
    assign frame_lt16 = !frame[7] && (frame[6:4] == 3'd0);

    // Pick offsets and colour for the current effect
    always_comb begin
        dx     = 4'd0;
        dy     = 2'd0;
        colour = pixel;
        keep   = (pixel != cfg.key_colour);
        case (effect_t'(cfg.effect_mode))
            EFF_SHAKE: begin
                if (frame_lt12) begin
                    dx = shake_dx(frame[3:0]);
                end
            end
            EFF_BOB: begin
                if (frame_lt16) begin
                    dy = bob_dy(frame[2:0]);
                end
            end
            EFF_FLASH: begin
                if (!frame[7] && (frame < FLASH_FRAMES) && frame[1]) begin
                    colour = tint_rgb565(pixel, FLASH_DELTA);
                end
            end
            EFF_PULSE: begin
                colour = tint_rgb565(pixel, pulse_delta(frame[7] ? 3'd0 : frame[2:0]));
            end
            EFF_SILHOUETTE: begin
                if (frame_lt16) begin
                    // odd frame pairs blink the sprite out
                    if (frame[1]) begin
                        keep = 1'b0;
                    end
                    dx     = {{2{jitter_dx(frame[3:0])}}};
                    dx     = {{2{dx[1]}}, dx[1:0]};
                    colour = tint_rgb565(cfg.fill_colour, pulse_delta(frame[2:0]));
                end
            end
            default: begin
            end
        endcase
    end

    // Screen position: origin plus offset plus place within the sprite
    assign x_pos = {{2{cfg.dest_x[10]}}, cfg.dest_x} + {{(POS_W-4){dx[3]}}, dx}
                 + {3'b000, column};
    assign y_pos = {{2{cfg.dest_y[10]}}, cfg.dest_y} + {{(POS_W-2){dy[1]}}, dy}
                 + {3'b000, row};

    // Clip against the screen
    assign x_in = !x_pos[POS_W-1] && (x_pos[POS_W-2:0] < (POS_W-1)'(SCREEN_COLUMNS));
    assign y_in = !y_pos[POS_W-1] && (y_pos[POS_W-2:0] < (POS_W-1)'(SCREEN_ROWS));

    assign result.draw    = keep && x_in && y_in;
    assign result.address = cfg.buffer_base + {12'd0, y_pos[9:0], 10'd0}
                          + {21'd0, x_pos[9:0], 1'b0};
    assign result.colour  = colour;

endmodule

>>> src/sprite_effect_blitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_effect_blitter
// Colour-keyed RGB565 sprite blitter with frame effects and screen clipping.
// ----------------------------------------------------------------------------
// Usage:
//   Sprite pixels enter on the s_ stream in raster order, one RGB565 value in
//   s_tdata, with s_tlast on the last pixel of the sprite. Each pixel that is
//   drawn leaves on the m_ stream as a framebuffer write request: byte address
//   in m_tdata[31:0], colour in m_tdata[47:32]. Key-coloured, clipped and
//   blinked-out pixels produce no request but still advance the counters.
//   Registers (width, origin, key, effect, frame, silhouette colour, base)
//   sit on the APB port at byte address 4*index; write them only while idle.
//   Each pixel taken passes the input register, then the result register.
//   Throughput: one pixel per cycle while the receiver keeps up, set by the
//   two-stage pipeline with a single pass of effect/clip/address logic.
//   Reset clears both pipeline stages and the column/row counters, and loads
//   the register defaults. When the receiver stalls, the result register
//   holds its request and the input stage keeps one more pixel; s_tready
//   drops only once both are full.
// ----------------------------------------------------------------------------
module sprite_effect_blitter
    import sfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Pixel stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] pixel_colour
    input  logic        s_tlast,   // last_of_sprite
    // Write request stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] write_address, [47:32] write_colour
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t               cfg_reg;
    logic [COUNT_W-1:0] col_count_reg;
    logic [COUNT_W-1:0] row_count_reg;
    logic [COUNT_W-1:0] col_count_next;
    logic [COUNT_W-1:0] row_count_next;
    logic               s1_valid_reg;
    logic [15:0]        s1_pixel_reg;
    logic [COUNT_W-1:0] s1_col_reg;
    logic [COUNT_W-1:0] s1_row_reg;
    logic               m_valid_reg;
    logic [47:0]        m_data_reg;
    logic               s_accept;
    logic               s1_advance;
    logic               cfg_write;
    logic [COUNT_W:0]   width_eff;
    pix_result_t        calc_result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.row_pixels   <= 10'd16;
            cfg_reg.dest_x       <= 11'd0;
            cfg_reg.dest_y       <= 11'd0;
            cfg_reg.key_colour   <= 16'hF81F;
            cfg_reg.effect_mode  <= 3'd0;
            cfg_reg.effect_frame <= 8'd0;
            cfg_reg.fill_colour  <= 16'd0;
            cfg_reg.buffer_base  <= 32'h0204_0000;
        end else if (cfg_write) begin
            case (paddr[4:2])
                REG_ROW_PIXELS:   cfg_reg.row_pixels   <= pwdata[9:0];
                REG_DEST_X:       cfg_reg.dest_x       <= pwdata[10:0];
                REG_DEST_Y:       cfg_reg.dest_y       <= pwdata[10:0];
                REG_KEY_COLOUR:   cfg_reg.key_colour   <= pwdata[15:0];
                REG_EFFECT_MODE:  cfg_reg.effect_mode  <= pwdata[2:0];
                REG_EFFECT_FRAME: cfg_reg.effect_frame <= pwdata[7:0];
                REG_SIL_COLOUR:   cfg_reg.fill_colour  <= pwdata[15:0];
                REG_BUFFER_BASE:  cfg_reg.buffer_base  <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (paddr[4:2])
            REG_ROW_PIXELS:   prdata = {22'd0, cfg_reg.row_pixels};
            REG_DEST_X:       prdata = {21'd0, cfg_reg.dest_x};
            REG_DEST_Y:       prdata = {21'd0, cfg_reg.dest_y};
            REG_KEY_COLOUR:   prdata = {16'd0, cfg_reg.key_colour};
            REG_EFFECT_MODE:  prdata = {29'd0, cfg_reg.effect_mode};
            REG_EFFECT_FRAME: prdata = {24'd0, cfg_reg.effect_frame};
            REG_SIL_COLOUR:   prdata = {16'd0, cfg_reg.fill_colour};
            REG_BUFFER_BASE:  prdata = cfg_reg.buffer_base;
            default:          prdata = 32'd0;
        endcase
    end

    // Pipeline handshake: stage 1 moves on when the result register is free
    assign s1_advance = !m_valid_reg || m_tready;
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign s_accept   = s_tvalid && s_tready;

    // Column and row counters; zero width means a full-side row
    assign width_eff = (cfg_reg.row_pixels == 10'd0) ? (COUNT_W+1)'(MAX_SPRITE_SIDE)
                                                    : {1'b0, cfg_reg.row_pixels};

    always_comb begin
        col_count_next = col_count_reg;
        row_count_next = row_count_reg;
        if (s_tlast) begin
            col_count_next = '0;
            row_count_next = '0;
        end else if (({1'b0, col_count_reg} + 1'b1) >= width_eff) begin
            col_count_next = '0;
            if (row_count_reg != COUNT_W'(MAX_SPRITE_SIDE - 1)) begin
                row_count_next = row_count_reg + 1'b1;
            end
        end else begin
            col_count_next = col_count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_accept) begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // Input stage: hold pixel and its place in the sprite
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pixel_reg <= s_tdata;
            s1_col_reg   <= col_count_reg;
            s1_row_reg   <= row_count_reg;
        end
    end

    sfb_pixel_calc u_pixel_calc (
        .cfg    (cfg_reg),
        .pixel  (s1_pixel_reg),
        .column (s1_col_reg),
        .row    (s1_row_reg),
        .result (calc_result)
    );

    // Result register: load drawn pixels, drop the rest
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= s1_valid_reg && calc_result.draw;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance && s1_valid_reg && calc_result.draw) begin
            m_data_reg <= {calc_result.colour, calc_result.address};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

>>> src/sfb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_checker
// Port-level checks for the sprite effect blitter, bound to the top level.
// ----------------------------------------------------------------------------
module sfb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        pready
);

    // Come out of reset with no request pending and room for a pixel
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("pipeline not cleared by reset");

    // A stalled request holds its payload
    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled request changed or vanished");

    // Back-pressure only while the result register is stuck
    a_ready_only_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // A new request always stems from a pixel taken into the input register
    a_request_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("request without a matching pixel");

    // Configuration port never waits
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind sprite_effect_blitter sfb_checker u_sfb_checker (.*);

>>> tb/sfb_write_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfb_write_checker
// Watches the pixel stream, the write request stream and the configuration
// port of the sprite effect blitter. Keeps its own copy of the registers and
// of the sprite column/row counters, works out the framebuffer write that each
// accepted pixel should cause and compares the requests in order, field by
// field. Hands the failure count and the number of writes still owed to the
// testbench top.
// ----------------------------------------------------------------------------
module sfb_write_checker
    import sfb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] pixel_colour
    input  logic        s_tlast,    // last_of_sprite
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,    // [31:0] write_address, [47:32] write_colour
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          owed_writes
);

    typedef struct packed {
        logic [31:0] address;
        logic [15:0] colour;
    } fb_write_t;

    cfg_t      regs;
    int        sprite_col;
    int        sprite_row;
    int        errors;
    int        row_len;
    fb_write_t fb_writes_due[$];
    fb_write_t due;
    fb_write_t seen;

    // Effect tables, indexed by frame
    function automatic int shake_step(input int i);
        case (i)
            1, 3:    return -4;
            2, 4:    return 4;
            5, 7:    return -2;
            6, 8:    return 2;
            9:       return -1;
            10:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int bob_step(input int i);
        case (i)
            1, 2:    return -1;
            5, 6:    return 1;
            default: return 0;
        endcase
    endfunction

    function automatic int pulse_step(input int i);
        case (i)
            0:       return -6;
            1, 7:    return -3;
            3, 5:    return 3;
            4:       return 6;
            default: return 0;
        endcase
    endfunction

    function automatic int jitter_step(input int i);
        case (i)
            2, 6, 12: return -1;
            4, 8, 14: return 1;
            default:  return 0;
        endcase
    endfunction

    function automatic int clamp_channel(input int v, input int top);
        if (v < 0)
            return 0;
        if (v > top)
            return top;
        return v;
    endfunction

    // Add delta to red and blue, twice to green, and clamp each channel
    function automatic logic [15:0] tint_565(input logic [15:0] c, input int d);
        int r;
        int g;
        int b;
        r = clamp_channel(int'(c[15:11]) + d, 31);
        g = clamp_channel(int'(c[10:5]) + 2 * d, 63);
        b = clamp_channel(int'(c[4:0]) + d, 31);
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    // Work out the write for one pixel at the given sprite place; 0 if none
    function automatic bit blit_pixel(input logic [15:0] pix, input int col,
                                      input int row, output fb_write_t wr);
        int          f;
        int          dx;
        int          dy;
        int          x;
        int          y;
        logic [31:0] ux;
        logic [31:0] uy;
        logic [15:0] colour;
        bit          drawn;
        f      = $signed(regs.effect_frame);
        dx     = 0;
        dy     = 0;
        colour = pix;
        drawn  = (pix != regs.key_colour);
        wr     = '0;
        case (regs.effect_mode)
            EFF_SHAKE: begin
                if (f >= 0 && f < 12)
                    dx = shake_step(f);
            end
            EFF_BOB: begin
                if (f >= 0 && f < 16)
                    dy = bob_step(f % 8);
            end
            EFF_FLASH: begin
                if (f >= 0 && f < int'(FLASH_FRAMES) && (f / 2) % 2 == 1)
                    colour = tint_565(pix, 8);
            end
            EFF_PULSE: begin
                colour = tint_565(pix, pulse_step(f < 0 ? 0 : f % 8));
            end
            EFF_SILHOUETTE: begin
                // blink out on odd half-frames, else jittered solid fill
                if (f >= 0 && f < 16) begin
                    if ((f / 2) % 2 == 1)
                        drawn = 1'b0;
                    dx     = jitter_step(f);
                    colour = tint_565(regs.fill_colour, pulse_step(f % 8));
                end
            end
            default: begin
            end
        endcase
        if (!drawn)
            return 1'b0;
        x = $signed(regs.dest_x);
        y = $signed(regs.dest_y);
        x = x + dx + col;
        y = y + dy + row;
        if (x < 0 || x >= SCREEN_COLUMNS || y < 0 || y >= SCREEN_ROWS)
            return 1'b0;
        ux = x;
        uy = y;
        wr.address = regs.buffer_base + (uy << 10) + (ux << 1);
        wr.colour  = colour;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            regs.row_pixels   = 10'd16;
            regs.dest_x       = '0;
            regs.dest_y       = '0;
            regs.key_colour   = 16'hF81F;
            regs.effect_mode  = EFF_PLAIN;
            regs.effect_frame = '0;
            regs.fill_colour  = '0;
            regs.buffer_base  = 32'h0204_0000;
            sprite_col        = 0;
            sprite_row        = 0;
            fb_writes_due.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_ROW_PIXELS:   regs.row_pixels   = pwdata[9:0];
                    REG_DEST_X:       regs.dest_x       = pwdata[10:0];
                    REG_DEST_Y:       regs.dest_y       = pwdata[10:0];
                    REG_KEY_COLOUR:   regs.key_colour   = pwdata[15:0];
                    REG_EFFECT_MODE:  regs.effect_mode  = pwdata[2:0];
                    REG_EFFECT_FRAME: regs.effect_frame = pwdata[7:0];
                    REG_SIL_COLOUR:   regs.fill_colour  = pwdata[15:0];
                    REG_BUFFER_BASE:  regs.buffer_base  = pwdata;
                    default: begin
                    end
                endcase
            end

            // Compare each write request with the oldest one owed
            if (m_tvalid && m_tready) begin
                seen.address = m_tdata[31:0];
                seen.colour  = m_tdata[47:32];
                if (fb_writes_due.size() == 0) begin
                    $display("%0t: unexpected write, expected none, got addr %h colour %h",
                             $time, seen.address, seen.colour);
                    errors++;
                end else begin
                    due = fb_writes_due.pop_front();
                    if (seen.address != due.address) begin
                        $display("%0t: write address mismatch, expected %h, got %h",
                                 $time, due.address, seen.address);
                        errors++;
                    end
                    if (seen.colour != due.colour) begin
                        $display("%0t: write colour mismatch, expected %h, got %h",
                                 $time, due.colour, seen.colour);
                        errors++;
                    end
                end
            end

            // Predict the write for each accepted pixel, then advance the place
            if (s_tvalid && s_tready) begin
                if (blit_pixel(s_tdata, sprite_col, sprite_row, due))
                    fb_writes_due.push_back(due);
                row_len = (regs.row_pixels == 0) ? MAX_SPRITE_SIDE
                                                 : int'(regs.row_pixels);
                if (s_tlast) begin
                    sprite_col = 0;
                    sprite_row = 0;
                end else if (sprite_col + 1 >= row_len) begin
                    sprite_col = 0;
                    if (sprite_row < MAX_SPRITE_SIDE - 1)
                        sprite_row++;
                end else begin
                    sprite_col++;
                end
            end
        end
        owed_writes <= fb_writes_due.size();
        fail_count  <= errors;
    end

endmodule

>>> tb/sprite_effect_blitter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_effect_blitter_test
// Drives sprite pixel runs and register settings into the blitter, with
// random sender gaps and receiver stalls, and leaves the checking to
// sfb_write_checker. Covers a short directed set, a long single-column
// sprite that runs the row counter into saturation, and random sprites over
// every effect mode under four gap/stall mixes.
// ----------------------------------------------------------------------------
module sprite_effect_blitter_test;
    import sfb_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 8;
    localparam int PHASE_COUNT  = 32;
    localparam int TALL_PIXELS  = 1030;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [4:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int owed_writes;
    int pixels_sent = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_left   = 0;
    int quiet_count = 0;
    bit squeeze_req = 1'b0;
    bit squeezed    = 1'b0;

    sprite_effect_blitter DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    sfb_write_checker u_write_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .owed_writes (owed_writes)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random stalls, plus one long hold-off when asked
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (squeeze_req && !squeezed) begin
            m_tready  <= 1'b0;
            hold_left <= HOLD_CYCLES;
            squeezed  <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog: give up when nothing is accepted for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_count <= 0;
        end else if (quiet_count >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_count <= quiet_count + 1;
        end
    end

    // One register write: setup phase, then access phase
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready)
            @(posedge aclk);
    endtask

    task automatic apply_cfg(input cfg_t c);
        write_reg(REG_ROW_PIXELS,   {22'd0, c.row_pixels});
        write_reg(REG_DEST_X,       {{21{c.dest_x[10]}}, c.dest_x});
        write_reg(REG_DEST_Y,       {{21{c.dest_y[10]}}, c.dest_y});
        write_reg(REG_KEY_COLOUR,   {16'd0, c.key_colour});
        write_reg(REG_EFFECT_MODE,  {29'd0, c.effect_mode});
        write_reg(REG_EFFECT_FRAME, {{24{c.effect_frame[7]}}, c.effect_frame});
        write_reg(REG_SIL_COLOUR,   {16'd0, c.fill_colour});
        write_reg(REG_BUFFER_BASE,  c.buffer_base);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one pixel after a random gap and hold it until taken
    task automatic send_pixel(input logic [15:0] pix, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        pixels_sent++;
    endtask

    // Stop sending and wait until every owed write has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (owed_writes != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    function automatic cfg_t default_cfg();
        cfg_t c;
        c.row_pixels   = 10'd16;
        c.dest_x       = '0;
        c.dest_y       = '0;
        c.key_colour   = 16'hF81F;
        c.effect_mode  = EFF_PLAIN;
        c.effect_frame = '0;
        c.fill_colour  = '0;
        c.buffer_base  = 32'h0204_0000;
        return c;
    endfunction

    function automatic logic [15:0] random_pixel(input logic [15:0] key);
        int pick;
        pick = $urandom_range(99);
        if (pick < 20)
            return key;
        if (pick < 25)
            return 16'h0000;
        if (pick < 30)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // Mostly on-screen settings with small frame indexes, now and then extremes
    function automatic cfg_t random_cfg(input logic [2:0] mode);
        cfg_t c;
        int   pick;
        int   pos;
        pick = $urandom_range(99);
        if (pick < 5)
            c.row_pixels = 10'd0;
        else if (pick < 10)
            c.row_pixels = 10'd1023;
        else
            c.row_pixels = 10'($urandom_range(1, 24));
        pick = $urandom_range(99);
        pos  = $urandom_range(0, 330) - 20;
        c.dest_x = (pick < 4) ? 11'h400 : ((pick < 8) ? 11'h3FF : pos[10:0]);
        pick = $urandom_range(99);
        pos  = $urandom_range(0, 250) - 20;
        c.dest_y = (pick < 4) ? 11'h400 : ((pick < 8) ? 11'h3FF : pos[10:0]);
        pick = $urandom_range(99);
        if (pick < 50)
            c.key_colour = 16'hF81F;
        else if (pick < 65)
            c.key_colour = 16'h0000;
        else if (pick < 80)
            c.key_colour = 16'hFFFF;
        else
            c.key_colour = 16'($urandom);
        c.effect_mode = mode;
        pick = $urandom_range(99);
        pos  = $urandom_range(0, 22) - 3;
        if (pick < 80)
            c.effect_frame = pos[7:0];
        else if (pick < 88)
            c.effect_frame = 8'h80;
        else if (pick < 94)
            c.effect_frame = 8'h7F;
        else
            c.effect_frame = 8'($urandom);
        c.fill_colour = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 15)
            c.buffer_base = 32'hFFFF_FFFF;
        else if (pick < 25)
            c.buffer_base = 32'h0;
        else
            c.buffer_base = $urandom;
        return c;
    endfunction

    // One sprite in raster order, no longer than the budget; some are cut
    // short, lose their end marker or carry a stray one mid-sprite
    task automatic send_sprite(input cfg_t c, input int budget);
        int   row_len;
        int   run;
        int   i;
        logic last;
        row_len = (c.row_pixels == 0) ? MAX_SPRITE_SIDE : int'(c.row_pixels);
        run     = row_len * $urandom_range(1, 6);
        if (run > 96)
            run = $urandom_range(1, 96);
        if ($urandom_range(99) < 15)
            run = $urandom_range(1, run);
        if (run > budget)
            run = budget;
        for (i = 0; i < run; i++) begin
            last = (i == run - 1);
            if ($urandom_range(99) < 3)
                last = ~last;
            send_pixel(random_pixel(c.key_colour), last);
        end
    endtask

    initial begin
        cfg_t c;
        int   p;
        int   i;
        int   target;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Register defaults: plain drawing at the origin, key colour dropped
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hF81F, 1'b0);
        send_pixel(16'hF81E, 1'b0);
        send_pixel(16'h0001, 1'b1);
        drain();

        // Flash on an odd half-frame brightens, clamped at the top
        c              = default_cfg();
        c.effect_mode  = EFF_FLASH;
        c.effect_frame = 8'd2;
        c.key_colour   = 16'h0000;
        apply_cfg(c);
        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h1234, 1'b1);
        drain();

        // Pulse with a negative frame takes the darkest step, clamped at zero
        c.effect_mode  = EFF_PULSE;
        c.effect_frame = 8'h80;
        c.key_colour   = 16'hF81F;
        apply_cfg(c);
        send_pixel(16'h0821, 1'b0);
        send_pixel(16'hF81F, 1'b0);
        send_pixel(16'hFFFF, 1'b1);
        drain();

        // Silhouette blinks out, then fills, then draws plain at the top frame
        c.effect_mode  = EFF_SILHOUETTE;
        c.effect_frame = 8'd3;
        c.fill_colour  = 16'hFFFF;
        apply_cfg(c);
        send_pixel(16'h1111, 1'b0);
        send_pixel(16'h2222, 1'b1);
        drain();
        c.effect_frame = 8'd4;
        apply_cfg(c);
        send_pixel(16'h1111, 1'b1);
        drain();
        c.effect_frame = 8'h7F;
        apply_cfg(c);
        send_pixel(16'h2222, 1'b1);
        drain();

        // Bottom-right corner with the top base wraps the address; next row clipped
        c             = default_cfg();
        c.row_pixels  = 10'd1;
        c.dest_x      = 11'd319;
        c.dest_y      = 11'd239;
        c.key_colour  = 16'hFFFF;
        c.buffer_base = 32'hFFFF_FFFF;
        apply_cfg(c);
        send_pixel(16'hABCD, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h1234, 1'b1);
        drain();

        // One column, more rows than the counter holds: row saturates
        c             = default_cfg();
        c.row_pixels  = 10'd1;
        c.dest_x      = 11'd5;
        c.dest_y      = 11'h418;
        c.buffer_base = 32'h0010_0000;
        apply_cfg(c);
        for (i = 0; i < TALL_PIXELS; i++)
            send_pixel(random_pixel(c.key_colour), i == TALL_PIXELS - 1);
        drain();

        // Random sprites: every mode under each gap/stall mix
        for (p = 0; p < PHASE_COUNT; p++) begin
            case (p / 8)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 59; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 59; end
                default: begin gap_pct = 18; stall_pct = 18; end
            endcase
            c = random_cfg(3'(p % 8));
            if (p == 0) begin
                // fill the pipeline against a long receiver hold-off
                c.row_pixels = 10'd16;
                c.dest_x     = 11'd8;
                c.dest_y     = 11'd8;
                c.key_colour = 16'hF81F;
                squeeze_req  = 1'b1;
            end
            apply_cfg(c);
            target = pixels_sent + PHASE_ITEMS;
            while (pixels_sent < target)
                send_sprite(c, target - pixels_sent);
            drain();
        end

        repeat (10) @(posedge aclk);
        if (fail_count == 0 && owed_writes == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
